// ===== hdl/xcfr_pkg.sv =====
// Shared types and constants for the XOR-checked frame receiver.
`default_nettype none
package xcfr_pkg;

   localparam int MAX_PAYLOAD = 16;
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_LEN     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0]  START_BYTE_RESET    = 8'd170;
   localparam logic [4:0]  FRAME_LEN_RESET     = 5'd12;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd300;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SHOW,
      BK_STATUS
   } back_state_type;

   // one unit of work for the emitter: a good frame or a tick status
   typedef struct packed {
      logic             is_status;
      logic             timed_out;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic frame_held;
   } q_status_type;

endpackage
`default_nettype wire

// ===== hdl/xor_checked_frame_receiver.sv =====
// Top level: start/length/payload/XOR-checksum deframer with link-age status.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: command, tdata: data_byte
//   rsp      out  rsp_tvalid/rsp_tready  tuser: kind, tlast: last,
//                                        tdata: payload_byte, link_timed_out
//   csr      in   csr_we                 csr_addr: register index, csr_wdata
//
// A tick request is queued as a status job and answered once the response side pops it.
// A good frame of N bytes is sent one byte at a time, each through a FETCH and a SHOW state,
// from the single-port-read payload RAM; requests are held off until its last byte goes.
// A two-entry job queue lets the parser run ahead of a stalled response side.
// Synchronous active-high reset restores register defaults and hunts for start.
`default_nettype none
module xor_checked_frame_receiver (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  wire logic                               req_tuser,  // [0] command
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [15:0]                        rsp_tdata,  // [7:0] payload_byte, [8] link_timed_out
   output      logic                               rsp_tlast,
   output      logic                               rsp_tuser,  // [0] kind
   input  wire logic                               csr_we,
   input  wire logic [xcfr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [xcfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   xcfr_pkg::q_status_type        q_status;
   xcfr_pkg::job_type             push_job;
   xcfr_pkg::job_type             head_job;
   logic                          push;
   logic                          pop;
   logic                          busy_frame;
   logic                          ram_wr_en;
   logic [xcfr_pkg::IDX_W-1:0]    ram_wr_addr;
   logic [7:0]                    ram_wr_data;
   logic [xcfr_pkg::IDX_W-1:0]    ram_rd_addr;
   logic [7:0]                    ram_rd_data;

   xcfr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .back_busy_frame (busy_frame),
      .push            (push),
      .push_job        (push_job),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data)
   );

   xcfr_ram #(
      .WIDTH (8),
      .DEPTH (xcfr_pkg::MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   xcfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   xcfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_status    (q_status),
      .pop         (pop),
      .busy_frame  (busy_frame),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== hdl/xcfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0]                                wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output      logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/xcfr_front.sv =====
// Front end: config registers, frame parser, payload writes and link-age counter.
`default_nettype none
module xcfr_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,
   input  wire logic                               req_tuser,
   input  wire logic                               csr_we,
   input  wire logic [xcfr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [xcfr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire xcfr_pkg::q_status_type             q_status,
   input  wire logic                               back_busy_frame,
   output      logic                               push,
   output      xcfr_pkg::job_type                  push_job,
   output      logic                               ram_wr_en,
   output      logic [xcfr_pkg::IDX_W-1:0]         ram_wr_addr,
   output      logic [7:0]                         ram_wr_data
);

   logic [7:0]  start_byte_ff;
   logic [4:0]  frame_len_ff;
   logic [15:0] timeout_ff;

   xcfr_pkg::phase_type             phase_ff, phase_in;
   logic [xcfr_pkg::CNT_W-1:0]      index_ff, index_in;
   logic [7:0]                      xor_ff, xor_in;
   logic [15:0]                     ticks_ff, ticks_in;

   logic accept;
   logic len_usable;
   logic [xcfr_pkg::CNT_W-1:0] index_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= xcfr_pkg::START_BYTE_RESET;
         frame_len_ff  <= xcfr_pkg::FRAME_LEN_RESET;
         timeout_ff    <= xcfr_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            xcfr_pkg::CSR_START_BYTE:    start_byte_ff <= csr_wdata[7:0];
            xcfr_pkg::CSR_FRAME_LEN:     frame_len_ff  <= csr_wdata[4:0];
            xcfr_pkg::CSR_TIMEOUT_TICKS: timeout_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xcfr_pkg::PH_HUNT;
         index_ff <= '0;
         xor_ff   <= '0;
         ticks_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
         ticks_ff <= ticks_in;
      end
   end

   // hold off while the job queue is full, or a good frame is queued or still reads out of the payload store
   assign req_tready = !q_status.full && !q_status.frame_held && !back_busy_frame;
   assign accept     = req_tvalid && req_tready;
   assign len_usable = (frame_len_ff != 5'd0) &&
                       (32'(frame_len_ff) <= xcfr_pkg::MAX_PAYLOAD);
   assign index_inc  = index_ff + xcfr_pkg::CNT_W'(1);

   always_comb begin
      phase_in           = phase_ff;
      index_in           = index_ff;
      xor_in             = xor_ff;
      ticks_in           = ticks_ff;
      push               = 1'b0;
      push_job.is_status = 1'b0;
      push_job.timed_out = 1'b0;
      push_job.count     = index_ff;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = index_ff[xcfr_pkg::IDX_W-1:0];
      ram_wr_data        = req_tdata;

      if (accept && req_tuser == xcfr_pkg::CMD_TICK) begin
         if (ticks_ff != 16'hFFFF) begin
            ticks_in = ticks_ff + 16'd1;
         end
         push               = 1'b1;
         push_job.is_status = 1'b1;
         push_job.timed_out = (ticks_in > timeout_ff);
      end else if (accept) begin
         case (phase_ff)
            xcfr_pkg::PH_HUNT: begin
               if (req_tdata == start_byte_ff) begin
                  phase_in = xcfr_pkg::PH_LEN;
               end
            end
            xcfr_pkg::PH_LEN: begin
               index_in = '0;
               xor_in   = '0;
               if (len_usable && req_tdata == {3'b000, frame_len_ff}) begin
                  phase_in = xcfr_pkg::PH_PAYLOAD;
               end else begin
                  phase_in = xcfr_pkg::PH_HUNT;
               end
            end
            xcfr_pkg::PH_PAYLOAD: begin
               if (!len_usable || 32'(index_ff) >= xcfr_pkg::MAX_PAYLOAD) begin
                  phase_in = xcfr_pkg::PH_HUNT;
               end else begin
                  ram_wr_en = 1'b1;
                  xor_in    = xor_ff ^ req_tdata;
                  index_in  = index_inc;
                  if (32'(index_inc) >= 32'(frame_len_ff)) begin
                     phase_in = xcfr_pkg::PH_CHECK;
                  end
               end
            end
            xcfr_pkg::PH_CHECK: begin
               if (len_usable && req_tdata == xor_ff &&
                   32'(index_ff) <= xcfr_pkg::MAX_PAYLOAD) begin
                  push     = 1'b1;
                  ticks_in = '0;
               end
               phase_in = xcfr_pkg::PH_HUNT;
            end
            default: phase_in = xcfr_pkg::PH_HUNT;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/xcfr_queue.sv =====
// Short job queue between the parser and the emitter.
`default_nettype none
module xcfr_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire xcfr_pkg::job_type        push_job,
   input  wire logic                     pop,
   output      xcfr_pkg::job_type        head_job,
   output      xcfr_pkg::q_status_type   status
);

   xcfr_pkg::job_type                 slot_ff [xcfr_pkg::QUEUE_DEPTH];
   logic [xcfr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [xcfr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [xcfr_pkg::QCNT_W-1:0]       used_ff, used_in;
   logic [xcfr_pkg::QCNT_W-1:0]       frames_ff, frames_in;

   logic do_push, do_pop;

   assign status.full       = (32'(used_ff) == xcfr_pkg::QUEUE_DEPTH);
   assign status.empty      = (used_ff == '0);
   assign status.frame_held = (frames_ff != '0);
   assign head_job          = slot_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      frames_in = frames_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == xcfr_pkg::QUEUE_DEPTH - 1) ? '0 :
                     wr_ptr_ff + xcfr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == xcfr_pkg::QUEUE_DEPTH - 1) ? '0 :
                     rd_ptr_ff + xcfr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         used_in = used_ff + xcfr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - xcfr_pkg::QCNT_W'(1);
      end
      // count of frame jobs held, used to protect the payload store
      if ((do_push && !push_job.is_status) && !(do_pop && !head_job.is_status)) begin
         frames_in = frames_ff + xcfr_pkg::QCNT_W'(1);
      end else if (!(do_push && !push_job.is_status) && (do_pop && !head_job.is_status)) begin
         frames_in = frames_ff - xcfr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
         frames_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
         frames_ff <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/xcfr_back.sv =====
// Back end: emits payload bytes of good frames and tick status responses.
`default_nettype none
module xcfr_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire xcfr_pkg::job_type            head_job,
   input  wire xcfr_pkg::q_status_type       q_status,
   output      logic                         pop,
   output      logic                         busy_frame,
   output      logic [xcfr_pkg::IDX_W-1:0]   ram_rd_addr,
   input  wire logic [7:0]                   ram_rd_data,
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   output      logic [15:0]                  rsp_tdata,
   output      logic                         rsp_tlast,
   output      logic                         rsp_tuser
);

   xcfr_pkg::back_state_type        state_ff, state_in;
   logic [xcfr_pkg::IDX_W-1:0]      ptr_ff, ptr_in;
   logic [xcfr_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                            timed_ff, timed_in;

   logic last_byte;

   assign last_byte   = (xcfr_pkg::CNT_W'(ptr_ff) + xcfr_pkg::CNT_W'(1)) == count_ff;
   assign ram_rd_addr = ptr_ff;
   assign busy_frame  = (state_ff == xcfr_pkg::BK_FETCH) || (state_ff == xcfr_pkg::BK_SHOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xcfr_pkg::BK_IDLE;
         ptr_ff   <= '0;
         count_ff <= '0;
         timed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         timed_ff <= timed_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      timed_in   = timed_ff;
      pop        = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = '0;
      rsp_tlast  = 1'b0;
      rsp_tuser  = xcfr_pkg::KIND_PAYLOAD;

      case (state_ff)
         xcfr_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               ptr_in   = '0;
               count_in = head_job.count;
               timed_in = head_job.timed_out;
               state_in = head_job.is_status ? xcfr_pkg::BK_STATUS : xcfr_pkg::BK_FETCH;
            end
         end
         xcfr_pkg::BK_FETCH: begin
            // read data for ptr lands at this edge and holds while ptr holds
            state_in = xcfr_pkg::BK_SHOW;
         end
         xcfr_pkg::BK_SHOW: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {8'h00, ram_rd_data};
            rsp_tlast  = last_byte;
            if (rsp_tready) begin
               if (last_byte) begin
                  state_in = xcfr_pkg::BK_IDLE;
               end else begin
                  ptr_in   = ptr_ff + xcfr_pkg::IDX_W'(1);
                  state_in = xcfr_pkg::BK_FETCH;
               end
            end
         end
         xcfr_pkg::BK_STATUS: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {7'h00, timed_ff, 8'h00};
            rsp_tlast  = 1'b1;
            rsp_tuser  = xcfr_pkg::KIND_STATUS;
            if (rsp_tready) begin
               state_in = xcfr_pkg::BK_IDLE;
            end
         end
         default: state_in = xcfr_pkg::BK_IDLE;
      endcase
   end

endmodule
`default_nettype wire
